FILE: rtl/core/hvt_pkg.sv
`default_nettype none
package hvt_pkg;

  localparam int unsigned CoefW    = 32;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned PairW    = 64;
  localparam int unsigned NumPairs = 8;
  localparam int unsigned NumCoef  = 16;
  localparam int unsigned IdxW     = 3;
  // exact sum of three coef*coord products and the w term
  localparam int unsigned AccW     = CoefW + CoordW + 2;

  localparam logic [NumPairs-1:0][PairW-1:0] PairReset = {
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd281474976710656, 64'd0, 64'd65536
  };

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } hvt_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     w_zero;
    logic                     saturated;
  } hvt_out_t;

  typedef struct packed {
    logic [AccW-1:0]   rem;
    logic [CoordW-1:0] nlow;
    logic [CoordW-1:0] quo;
  } hvt_lane_t;

  typedef struct packed {
    logic       valid;
    logic       w_zero;
    logic [2:0] neg;
    logic [2:0] ovf;
  } hvt_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/hvt_dot.sv
`default_nettype none
module hvt_dot import hvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire hvt_in_t                           in_i,
  input  wire logic [NumCoef-1:0][CoefW-1:0]     coef_i,
  output logic                                   valid_o,
  output logic [3:0][AccW-1:0]                   acc_o
);

  localparam int unsigned PW = CoefW + CoordW;

  logic signed [CoordW-1:0] crd [3];
  logic signed [PW-1:0]     prod_d [4][3];
  logic signed [PW-1:0]     prod_q [4][3];
  logic signed [AccW-1:0]   wterm_d [4];
  logic signed [AccW-1:0]   wterm_q [4];
  logic [3:0][AccW-1:0]     acc_d;
  logic [3:0][AccW-1:0]     acc_q;
  logic                     v1_q, v2_q;

  assign crd[0] = in_i.in_x;
  assign crd[1] = in_i.in_y;
  assign crd[2] = in_i.in_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PW'($signed(coef_i[in_i.op ? 4'(4*r+c) : 4'(r+4*c)]) * crd[c]);
      end
      // implied w of one
      wterm_d[r] = AccW'($signed(coef_i[in_i.op ? 4'(4*r+3) : 4'(r+12)])) <<< FRAC_BITS;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc_d[r] = AccW'(prod_q[r][0]) + AccW'(prod_q[r][1]) + AccW'(prod_q[r][2])
               + wterm_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    wterm_q <= wterm_d;
    acc_q   <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign acc_o   = acc_q;

endmodule
`default_nettype wire

FILE: rtl/core/hvt_div_cell.sv
`default_nettype none
module hvt_div_cell import hvt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hvt_ctl_t        ctl_i,
  input  wire hvt_lane_t [2:0] lane_i,
  input  wire logic [AccW-1:0] den_i,
  output hvt_ctl_t             ctl_o,
  output hvt_lane_t [2:0]      lane_o,
  output logic [AccW-1:0]      den_o
);

  hvt_lane_t [2:0]  lane_d, lane_q;
  logic [AccW-1:0]  den_q;
  logic [AccW:0]    trial [3];
  logic [2:0]       ge;

  // one restoring step per lane: bring down the next numerator bit
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l] = {lane_i[l].rem, lane_i[l].nlow[CoordW-1]};
      ge[l]    = trial[l] >= {1'b0, den_i};
      lane_d[l].rem  = ge[l] ? AccW'(trial[l] - {1'b0, den_i}) : AccW'(trial[l]);
      lane_d[l].nlow = {lane_i[l].nlow[CoordW-2:0], 1'b0};
      lane_d[l].quo  = {lane_i[l].quo[CoordW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    den_q  <= den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  assign lane_o = lane_q;
  assign den_o  = den_q;

endmodule
`default_nettype wire

FILE: rtl/core/homogeneous_vertex_transform_top.sv
`default_nettype none
// point transform by a 4x4 q16.16 matrix with perspective divide
// configuration: cfg_we_i writes cfg_data_i into coefficient pair cfg_idx_i
// at the clock edge; pair k holds entry 2k in bits 31..0 and 2k+1 in 63..32,
// column-major for op 0 and row-major for op 1. write only while no word is in flight.
// input: a word is taken at each edge where start_i is high and busy_o is
// low; busy_o is always low, so one word may enter every cycle.
// output: done_o is high for exactly one cycle with res_o holding the word;
// the receiver cannot stall, so nothing is held back.
// pipeline: the word is registered by the multiply stage at the accepting
// edge, then passes one sum stage, one magnitude stage, one divider cell per
// quotient bit and one saturation stage, whose register drives done_o and
// res_o. throughput one word per cycle, set by the chain of divider cells
// each taking a new word every cycle.
// reset: the matrix returns to identity and words in flight are dropped.
module homogeneous_vertex_transform_top import hvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IdxW-1:0]  cfg_idx_i,
  input  wire logic [PairW-1:0] cfg_data_i,
  input  wire logic             start_i,
  input  wire hvt_in_t          in_i,
  output logic                  busy_o,
  output logic                  done_o,
  output hvt_out_t              res_o
);

  localparam int unsigned NW = AccW + FRAC_BITS + CoordW;

  logic [NumPairs-1:0][PairW-1:0] pair_q;
  logic [NumCoef-1:0][CoefW-1:0]  coef;
  logic                           dot_valid;
  logic [3:0][AccW-1:0]           acc;

  logic [2:0][AccW-1:0] nmag_q;
  logic [AccW-1:0]      dmag_q;
  logic [2:0]           neg_q;
  logic                 wz_q, mv_q;

  hvt_ctl_t             ctl   [CoordW+1];
  hvt_lane_t [2:0]      lane  [CoordW+1];
  logic [AccW-1:0]      den   [CoordW+1];
  logic [NW-1:0]        num   [3];

  hvt_out_t res_d, res_q;
  logic     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= PairReset;
    end else if (cfg_we_i) begin
      pair_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < NumPairs; k++) begin
      coef[2*k]   = pair_q[k][CoefW-1:0];
      coef[2*k+1] = pair_q[k][PairW-1:CoefW];
    end
  end

  assign busy_o = 1'b0;

  hvt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .in_i,
    .coef_i  (coef),
    .valid_o (dot_valid),
    .acc_o   (acc)
  );

  // sign and magnitude of numerators and w
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      nmag_q[l] <= acc[l][AccW-1] ? AccW'(-acc[l]) : acc[l];
      neg_q[l]  <= acc[l][AccW-1] ^ acc[3][AccW-1];
    end
    dmag_q <= acc[3][AccW-1] ? AccW'(-acc[3]) : acc[3];
    wz_q   <= acc[3] == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= dot_valid;
    end
  end

  // overflow when the quotient needs more than COORD_WIDTH bits
  always_comb begin
    ctl[0].valid  = mv_q;
    ctl[0].w_zero = wz_q;
    ctl[0].neg    = neg_q;
    for (int l = 0; l < 3; l++) begin
      num[l]           = NW'(nmag_q[l]) << FRAC_BITS;
      ctl[0].ovf[l]    = num[l] >= (NW'(dmag_q) << CoordW);
      lane[0][l].rem   = AccW'(num[l] >> CoordW);
      lane[0][l].nlow  = num[l][CoordW-1:0];
      lane[0][l].quo   = '0;
    end
    den[0] = dmag_q;
  end

  for (genvar i = 0; i < CoordW; i++) begin : g_cell
    hvt_div_cell u_cell (
      .clk_i, .rst_ni,
      .ctl_i  (ctl[i]),
      .lane_i (lane[i]),
      .den_i  (den[i]),
      .ctl_o  (ctl[i+1]),
      .lane_o (lane[i+1]),
      .den_o  (den[i+1])
    );
  end

  always_comb begin
    logic [CoordW-1:0] q;
    logic [2:0]        sat;
    logic [CoordW-1:0] val [3];
    for (int l = 0; l < 3; l++) begin
      q = lane[CoordW][l].quo;
      if (ctl[CoordW].neg[l]) begin
        sat[l] = ctl[CoordW].ovf[l] | (q[CoordW-1] & (|q[CoordW-2:0]));
        val[l] = sat[l] ? {1'b1, {(CoordW-1){1'b0}}} : CoordW'(-q);
      end else begin
        sat[l] = ctl[CoordW].ovf[l] | q[CoordW-1];
        val[l] = sat[l] ? {1'b0, {(CoordW-1){1'b1}}} : q;
      end
    end
    if (ctl[CoordW].w_zero) begin
      res_d = '0;
      res_d.w_zero = 1'b1;
    end else begin
      res_d.out_x     = val[0];
      res_d.out_y     = val[1];
      res_d.out_z     = val[2];
      res_d.w_zero    = 1'b0;
      res_d.saturated = |sat;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl[CoordW].valid;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: tb/sv/homogeneous_vertex_transform_top_tb.sv
`default_nettype none
module homogeneous_vertex_transform_top_tb;
  import hvt_pkg::*;

  localparam int unsigned Frac = 16;
  localparam int unsigned DrainCycles = CoordW + 8;
  localparam longint unsigned CycleLimit = 200000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IdxW-1:0]  cfg_idx_i;
  logic [PairW-1:0] cfg_data_i;
  logic             start_i;
  hvt_in_t          in_i;
  logic             busy_o;
  logic             done_o;
  hvt_out_t         res_o;

  homogeneous_vertex_transform_top #(.FRAC_BITS(Frac)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start_i(start_i), .in_i(in_i), .busy_o(busy_o),
    .done_o(done_o), .res_o(res_o)
  );

  logic [PairW-1:0] matrix_pairs [NumPairs];
  hvt_out_t         pending_vertices [$];
  int unsigned      idle_pct;
  int unsigned      errors;
  int unsigned      words_sent;
  int unsigned      words_checked;
  int unsigned      sat_seen;
  int unsigned      wzero_seen;
  longint unsigned  cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("homogeneous_vertex_transform_top test failed");
      $finish;
    end
  end

  // truncated quotient in F fraction bits, clamped to the coordinate range
  function automatic logic [CoordW-1:0] divide_lane(logic signed [127:0] num,
                                                   logic signed [127:0] den,
                                                   inout bit sat);
    logic [127:0] nmag, dmag, q;
    bit neg;
    neg  = (num < 0) != (den < 0);
    nmag = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    q    = (nmag << Frac) / dmag;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return -q[CoordW-1:0];
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    return q[CoordW-1:0];
  endfunction

  function automatic hvt_out_t transform_vertex(hvt_in_t v);
    logic signed [127:0] acc [4];
    logic signed [127:0] coord [4];
    logic signed [127:0] cf;
    logic signed [CoefW-1:0] entry;
    int unsigned idx;
    bit sat;
    hvt_out_t r;
    coord[0] = v.in_x;
    coord[1] = v.in_y;
    coord[2] = v.in_z;
    coord[3] = 128'sd1 <<< Frac;
    for (int row = 0; row < 4; row++) begin
      acc[row] = '0;
      for (int col = 0; col < 4; col++) begin
        idx   = v.op ? 4 * row + col : row + 4 * col;
        entry = matrix_pairs[idx >> 1][(idx & 1) * 32 +: 32];
        cf    = entry;
        acc[row] = acc[row] + cf * coord[col];
      end
    end
    r = '0;
    if (acc[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    sat = 1'b0;
    r.out_x = divide_lane(acc[0], acc[3], sat);
    r.out_y = divide_lane(acc[1], acc[3], sat);
    r.out_z = divide_lane(acc[2], acc[3], sat);
    r.saturated = sat;
    return r;
  endfunction

  // one word in, prediction taken at the accepting edge
  task automatic send_vertex(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    hvt_in_t w;
    w.op = op;
    w.in_x = x;
    w.in_y = y;
    w.in_z = z;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    pending_vertices.push_back(transform_vertex(w));
    words_sent++;
    @(negedge clk_i);
  endtask

  // sender pauses until every word is back, then the pipe is let run empty
  task automatic drain_pipe();
    start_i <= 1'b0;
    while (pending_vertices.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_pair(input int unsigned idx, input logic [PairW-1:0] val);
    drain_pipe();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[IdxW-1:0];
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    matrix_pairs[idx] = val;
  endtask

  task automatic load_matrix(input logic [31:0] e [16]);
    for (int k = 0; k < NumPairs; k++) write_pair(k, {e[2 * k + 1], e[2 * k]});
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      2: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] random_entry(int unsigned style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
      default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic test_identity_extremes();
    logic [31:0] ext [6];
    ext = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
            32'h0001_0000, 32'h5555_aaaa};
    for (int i = 0; i < 6; i++) begin
      send_vertex(1'b0, ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6]);
      send_vertex(1'b1, ext[(i + 3) % 6], ext[i], ext[(i + 4) % 6]);
    end
  endtask

  task automatic test_transposed_and_wzero();
    logic [31:0] e [16];
    // translation in column 3, w row picks up x so it can vanish
    e = '{32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000,
          32'h0, 32'h0001_0000, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0001_0000, 32'h0,
          32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, 32'h0001_0000};
    load_matrix(e);
    send_vertex(1'b0, 32'hffff_8000, 32'h0001_0000, 32'h0002_0000);
    send_vertex(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(1'b1, 32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_vertex(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    // tiny w against large numerator forces clamping both ways
    send_vertex(1'b0, 32'hffff_8001, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(1'b0, 32'hffff_7fff, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_extreme_matrices();
    logic [PairW-1:0] pats [4];
    pats = '{64'hffff_ffff_ffff_ffff, 64'h8000_0000_8000_0000,
             64'h7fff_ffff_7fff_ffff, 64'h0000_0000_0000_0000};
    foreach (pats[p]) begin
      for (int k = 0; k < NumPairs; k++) write_pair(k, pats[p]);
      send_vertex(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    end
  endtask

  task automatic test_random(input int unsigned pct, input int unsigned n_mats);
    logic [31:0] e [16];
    int unsigned style;
    idle_pct = pct;
    repeat (n_mats) begin
      style = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 2);
      foreach (e[i]) e[i] = random_entry(style);
      if ($urandom_range(3) == 0) begin
        // mostly affine: w row of the column-major layout near one
        e[3] = '0; e[7] = '0; e[11] = '0;
        e[15] = 32'h0001_0000 + $urandom_range(255);
      end
      load_matrix(e);
      repeat (50) send_vertex($urandom_range(1), random_coord(), random_coord(),
                              random_coord());
    end
    drain_pipe();
  endtask

  always @(posedge clk_i) begin
    hvt_out_t exp_v;
    if (rst_ni && done_o) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        errors++;
      end else begin
        exp_v = pending_vertices.pop_front();
        words_checked++;
        if (exp_v.saturated) sat_seen++;
        if (exp_v.w_zero) wzero_seen++;
        if (res_o.out_x !== exp_v.out_x || res_o.out_y !== exp_v.out_y ||
            res_o.out_z !== exp_v.out_z || res_o.w_zero !== exp_v.w_zero ||
            res_o.saturated !== exp_v.saturated) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b sat=%b", $time,
                   exp_v.out_x, exp_v.out_y, exp_v.out_z, exp_v.w_zero, exp_v.saturated);
          $display("%0t:          actual   x=%h y=%h z=%h wz=%b sat=%b", $time,
                   res_o.out_x, res_o.out_y, res_o.out_z, res_o.w_zero, res_o.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    sat_seen = 0;
    wzero_seen = 0;
    idle_pct = 0;
    for (int k = 0; k < NumPairs; k++) matrix_pairs[k] = PairReset[k];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    start_i = 1'b0;
    in_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_identity_extremes();
    test_transposed_and_wzero();
    test_extreme_matrices();
    test_random(9, 4);
    test_random(59, 4);
    test_random(0, 4);
    drain_pipe();
    $display("%0d words sent, %0d checked, %0d saturated, %0d with zero w",
             words_sent, words_checked, sat_seen, wzero_seen);
    $display("covered identity, transposed, extreme and random matrices under idle gaps");
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("homogeneous_vertex_transform_top test passed");
    end else begin
      $display("homogeneous_vertex_transform_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
